>>> src/spm_pkg.sv
// Package for the segmented prediction MSE block: types, constants and codes.
`timescale 1ns / 1ps
package spm_pkg;

    // Depth of the per-axis error delay ring.
    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    localparam int LBL_W  = 8;
    localparam int SMP_W  = 16;
    localparam int ERR_W  = SMP_W + 1;
    localparam int SQ_W   = 2 * SMP_W;
    localparam int SUM_W  = 46;
    localparam int CNT_W  = 13;
    localparam int MEAN_W = 32;
    localparam int AXES   = 3;

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CNT_W-1:0]        COUNT_LIMIT     = '1;
    localparam logic signed [LBL_W-1:0] STRONG_LOW_RST  = 8'sd9;
    localparam logic signed [LBL_W-1:0] STRONG_HIGH_RST = 8'sd14;
    localparam logic [CNT_W-1:0]        MAX_COUNT_RST   = 13'd4800;
    localparam logic [CNT_W-1:0]        MIN_COUNT_RST   = 13'd60;

    typedef struct packed {
        logic signed [LBL_W-1:0] state;
        logic signed [SMP_W-1:0] predicted_x;
        logic signed [SMP_W-1:0] predicted_y;
        logic signed [SMP_W-1:0] predicted_z;
        logic signed [SMP_W-1:0] actual_x;
        logic signed [SMP_W-1:0] actual_y;
        logic signed [SMP_W-1:0] actual_z;
    } t_in_item;

    typedef struct packed {
        logic              segment_done;
        logic              segment_trusted;
        logic [MEAN_W-1:0] mean_sq_x;
        logic [MEAN_W-1:0] mean_sq_y;
        logic [MEAN_W-1:0] mean_sq_z;
    } t_out_item;

    typedef struct packed {
        logic signed [LBL_W-1:0] strong_low;
        logic signed [LBL_W-1:0] strong_high;
        logic [CNT_W-1:0]        max_count;
        logic [CNT_W-1:0]        min_count;
    } t_cfg;

    typedef enum logic [1:0] {
        REG_STRONG_LOW  = 2'd0,
        REG_STRONG_HIGH = 2'd1,
        REG_MAX_COUNT   = 2'd2,
        REG_MIN_COUNT   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_SQUARE,
        S_ACCUM,
        S_DIV,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic ring_write;
        logic ring_read;
        logic square;
        logic accum;
        logic clear;
        logic div_start;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close;
        logic in_range;
        logic count_sat;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

>>> src/spm_regs.sv
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps
module spm_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [spm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [spm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output spm_pkg::t_cfg                    o_cfg
);

    spm_pkg::t_cfg     r_cfg;
    spm_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = spm_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strong_low  <= spm_pkg::STRONG_LOW_RST;
            r_cfg.strong_high <= spm_pkg::STRONG_HIGH_RST;
            r_cfg.max_count   <= spm_pkg::MAX_COUNT_RST;
            r_cfg.min_count   <= spm_pkg::MIN_COUNT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                spm_pkg::REG_STRONG_LOW:  r_cfg.strong_low  <= pwdata[spm_pkg::LBL_W-1:0];
                spm_pkg::REG_STRONG_HIGH: r_cfg.strong_high <= pwdata[spm_pkg::LBL_W-1:0];
                spm_pkg::REG_MAX_COUNT:   r_cfg.max_count   <= pwdata[spm_pkg::CNT_W-1:0];
                spm_pkg::REG_MIN_COUNT:   r_cfg.min_count   <= pwdata[spm_pkg::CNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            spm_pkg::REG_STRONG_LOW:
                prdata = {{(spm_pkg::APB_DATA_W - spm_pkg::LBL_W){1'b0}}, r_cfg.strong_low};
            spm_pkg::REG_STRONG_HIGH:
                prdata = {{(spm_pkg::APB_DATA_W - spm_pkg::LBL_W){1'b0}}, r_cfg.strong_high};
            spm_pkg::REG_MAX_COUNT:
                prdata = {{(spm_pkg::APB_DATA_W - spm_pkg::CNT_W){1'b0}}, r_cfg.max_count};
            spm_pkg::REG_MIN_COUNT:
                prdata = {{(spm_pkg::APB_DATA_W - spm_pkg::CNT_W){1'b0}}, r_cfg.min_count};
        endcase
    end

endmodule

>>> src/spm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module spm_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [spm_pkg::SUM_W-1:0]     i_dividend,
    input  logic [spm_pkg::CNT_W-1:0]     i_divisor,
    output logic [spm_pkg::MEAN_W-1:0]    o_quotient,
    output logic                          o_busy
);

    localparam int SW = spm_pkg::SUM_W;
    localparam int CW = spm_pkg::CNT_W;
    localparam int KW = spm_pkg::DIV_CNT_W;

    logic [KW-1:0] r_step;
    logic [SW-1:0] r_quo;
    logic [CW:0]   r_rem;
    logic [CW-1:0] r_div;

    logic [CW:0]   w_shift;
    logic          w_ge;
    logic [CW:0]   w_rem_next;

    // The partial remainder stays below the divisor, so CW bits of it plus
    // the incoming dividend bit never overflow CW+1 bits.
    assign w_shift    = {r_rem[CW-1:0], r_quo[SW-1]};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_rem_next = w_ge ? (w_shift - {1'b0, r_div}) : w_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_start) begin
            r_step <= KW'(spm_pkg::DIV_STEPS);
        end else if (r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_step != '0) begin
            r_quo <= {r_quo[SW-2:0], w_ge};
            r_rem <= w_rem_next;
        end
    end

    assign o_quotient = r_quo[spm_pkg::MEAN_W-1:0];
    assign o_busy     = (r_step != '0);

endmodule

>>> src/spm_datapath.sv
// Datapath: error ring, squaring, per-axis sums, count, dividers and output register.
`timescale 1ns / 1ps
module spm_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spm_pkg::t_cfg        i_cfg,
    input  spm_pkg::t_in_item    i_in_data,
    input  spm_pkg::t_cmd        i_cmd,
    output spm_pkg::t_status     o_status,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output spm_pkg::t_out_item   o_out_data
);

    localparam int PW = spm_pkg::PTR_W;
    localparam int EW = spm_pkg::ERR_W;
    localparam int NA = spm_pkg::AXES;

    // Captured item.
    logic signed [spm_pkg::LBL_W-1:0] r_label;
    logic signed [spm_pkg::SMP_W-1:0] r_pred [NA];
    logic signed [spm_pkg::SMP_W-1:0] r_act  [NA];

    // Block state.
    logic signed [spm_pkg::SMP_W-1:0] r_last_pred [NA];
    logic signed [spm_pkg::LBL_W-1:0] r_prev_label;
    logic [PW-1:0]                    r_wp;
    logic [PW-1:0]                    r_tail;
    logic [spm_pkg::SUM_W-1:0]        r_sum [NA];
    logic [spm_pkg::CNT_W-1:0]        r_count;
    logic                             r_close;

    // Error ring: one row holds the three axes.
    logic [NA*EW-1:0]                 r_ring [spm_pkg::RING_DEPTH];
    logic [spm_pkg::RING_DEPTH-1:0]   r_ring_vld;
    logic [NA*EW-1:0]                 r_rd_row;
    logic                             r_rd_vld;

    logic [spm_pkg::SQ_W-1:0]         r_sq [NA];

    logic                             r_out_valid;
    spm_pkg::t_out_item               r_out_data;

    logic signed [EW-1:0]             w_err [NA];
    logic signed [EW-1:0]             w_rd_err [NA];
    logic [EW-1:0]                    w_mag [NA];
    logic [PW-1:0]                    w_wp_next;
    logic [PW:0]                      w_tail_sum;
    logic [PW-1:0]                    w_tail_next;
    logic                             w_close;
    logic                             w_strong;
    logic [spm_pkg::MEAN_W-1:0]       w_quo [NA];
    logic [NA-1:0]                    w_busy;

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            w_err[a]    = $signed({r_act[a][spm_pkg::SMP_W-1], r_act[a]})
                        - $signed({r_last_pred[a][spm_pkg::SMP_W-1], r_last_pred[a]});
            w_rd_err[a] = $signed(r_rd_row[(NA-1-a)*EW +: EW]);
            w_mag[a]    = w_rd_err[a][EW-1] ? EW'(-w_rd_err[a]) : EW'(w_rd_err[a]);
        end
    end

    // The tail sits two places after the write slot, modulo the ring depth.
    assign w_wp_next   = (r_wp == PW'(spm_pkg::RING_DEPTH - 1)) ? '0 : (r_wp + 1'b1);
    assign w_tail_sum  = {1'b0, w_wp_next} + (PW+1)'(1);
    assign w_tail_next = (w_tail_sum >= (PW+1)'(spm_pkg::RING_DEPTH))
                       ? PW'(w_tail_sum - (PW+1)'(spm_pkg::RING_DEPTH))
                       : w_tail_sum[PW-1:0];

    assign w_close  = ((r_label != r_prev_label) && (r_count != '0))
                   || (r_count > i_cfg.max_count);
    assign w_strong = ($signed(r_label) >= $signed(i_cfg.strong_low))
                   && ($signed(r_label) <= $signed(i_cfg.strong_high));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_label  <= i_in_data.state;
            r_pred[0] <= i_in_data.predicted_x;
            r_pred[1] <= i_in_data.predicted_y;
            r_pred[2] <= i_in_data.predicted_z;
            r_act[0]  <= i_in_data.actual_x;
            r_act[1]  <= i_in_data.actual_y;
            r_act[2]  <= i_in_data.actual_z;
        end
        if (i_cmd.ring_write) begin
            r_tail  <= w_tail_next;
            r_close <= w_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_write) begin
            r_ring[r_wp] <= {w_err[0], w_err[1], w_err[2]};
        end
        if (i_cmd.ring_read) begin
            r_rd_row <= r_ring[r_tail];
            r_rd_vld <= r_ring_vld[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            for (int a = 0; a < NA; a++) begin
                r_sq[a] <= r_rd_vld ? (w_mag[a][spm_pkg::SMP_W-1:0] * w_mag[a][spm_pkg::SMP_W-1:0])
                                    : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_ring_vld   <= '0;
            r_prev_label <= '0;
            r_count      <= '0;
            for (int a = 0; a < NA; a++) begin
                r_last_pred[a] <= '0;
                r_sum[a]       <= '0;
            end
        end else begin
            if (i_cmd.ring_write) begin
                r_wp             <= w_wp_next;
                r_ring_vld[r_wp] <= 1'b1;
                for (int a = 0; a < NA; a++) begin
                    r_last_pred[a] <= r_pred[a];
                end
            end
            if (i_cmd.clear || (i_cmd.emit && r_close)) begin
                r_count <= '0;
                for (int a = 0; a < NA; a++) begin
                    r_sum[a] <= '0;
                end
            end else if (i_cmd.accum) begin
                r_count <= r_count + 1'b1;
                for (int a = 0; a < NA; a++) begin
                    r_sum[a] <= r_sum[a] + {{(spm_pkg::SUM_W - spm_pkg::SQ_W){1'b0}}, r_sq[a]};
                end
            end
            if (i_cmd.emit) begin
                r_prev_label <= r_label;
            end
        end
    end

    for (genvar g = 0; g < NA; g++) begin : g_div
        spm_divider u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.div_start),
            .i_dividend (r_sum[g]),
            .i_divisor  (r_count),
            .o_quotient (w_quo[g]),
            .o_busy     (w_busy[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.segment_done    <= r_close;
            r_out_data.segment_trusted <= r_close && (r_count >= i_cfg.min_count);
            r_out_data.mean_sq_x       <= r_close ? w_quo[0] : '0;
            r_out_data.mean_sq_y       <= r_close ? w_quo[1] : '0;
            r_out_data.mean_sq_z       <= r_close ? w_quo[2] : '0;
        end
    end

    assign o_status.close     = w_close;
    assign o_status.in_range  = w_strong;
    assign o_status.count_sat = (r_count == spm_pkg::COUNT_LIMIT);
    assign o_status.div_busy  = |w_busy;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> src/spm_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module spm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  spm_pkg::t_status  i_status,
    output spm_pkg::t_cmd     o_cmd,
    output logic              o_in_stall
);

    spm_pkg::t_state r_state;
    spm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            spm_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = spm_pkg::S_WRITE;
                end
            end
            spm_pkg::S_WRITE: begin
                o_cmd.ring_write = 1'b1;
                priority if (i_status.close) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = spm_pkg::S_DIV;
                end else if (i_status.in_range && !i_status.count_sat) begin
                    n_state = spm_pkg::S_READ;
                end else if (i_status.in_range) begin
                    n_state = spm_pkg::S_EMIT;
                end else begin
                    o_cmd.clear = 1'b1;
                    n_state     = spm_pkg::S_EMIT;
                end
            end
            spm_pkg::S_READ: begin
                o_cmd.ring_read = 1'b1;
                n_state         = spm_pkg::S_SQUARE;
            end
            spm_pkg::S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = spm_pkg::S_ACCUM;
            end
            spm_pkg::S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = spm_pkg::S_EMIT;
            end
            spm_pkg::S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = spm_pkg::S_EMIT;
                end
            end
            spm_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = spm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> src/segmented_prediction_mse_core.sv
// Top level of the segmented prediction mean-squared-error block.
// Path from input transfer to result in the output register: capture and ring write, then
// straight to the result when the segment is cleared or the count is saturated, through
// read, square and accumulate when a squared error is accumulated, or through the 46-step
// bit-serial divider on a segment close. A new item is taken only once the last is emitted.
// Reset is synchronous, active low, and clears control, sums and ring valid bits with no clearing pass.
`timescale 1ns / 1ps
module segmented_prediction_mse_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Input item channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  spm_pkg::t_in_item                i_in_data,

    // Result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output spm_pkg::t_out_item               o_out_data,

    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [spm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [spm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [spm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    // Every accepted item produces exactly one result transfer. The block
    // works on one item at a time: the controller takes a transfer only in
    // its idle state, walks the item through the datapath, and hands the
    // result to the output register. That register decouples the two sides,
    // so a new input transfer is taken while an earlier result still waits.

    spm_pkg::t_cfg    w_cfg;
    spm_pkg::t_cmd    w_cmd;
    spm_pkg::t_status w_status;

    // Configuration registers. Writes are expected only while the block is idle.
    spm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The controller issues its commands step by step: capture, ring write with the
    // close decision, then either the divider run, the read-square-accumulate
    // sequence, or straight to the result.
    spm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath holds the error ring with a valid bit per row, so entries
    // never written square to zero. The read of the delayed error happens in the
    // cycle after the write, which also covers a two-entry ring where the
    // write slot and the delayed slot coincide.
    spm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> src/spm_checker.sv
// Port-level assertions for the segmented prediction MSE block and their bind.
`timescale 1ns / 1ps
module spm_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  spm_pkg::t_out_item    o_out_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // The block works on one item at a time.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // Only a closed segment can be trusted.
    a_trust_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.segment_trusted |-> o_out_data.segment_done)
        else $error("trusted flag without a closed segment");

    // A result without a close carries zero means.
    a_zero_means: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.segment_done |->
            (o_out_data.mean_sq_x == '0) && (o_out_data.mean_sq_y == '0)
            && (o_out_data.mean_sq_z == '0))
        else $error("nonzero mean on an open segment");

endmodule

bind segmented_prediction_mse_core spm_checker u_spm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> sim/segmented_prediction_mse_core_tb.sv
// Self-checking testbench for the segmented prediction mean-squared-error core.
`timescale 1ns / 1ps
module segmented_prediction_mse_core_tb;

    // Widths taken from the package, kept short for the casts below.
    localparam int SW = spm_pkg::SUM_W;
    localparam int MW = spm_pkg::MEAN_W;
    localparam int NA = spm_pkg::AXES;
    localparam int ND = spm_pkg::RING_DEPTH;

    // Timing of the run. The clock period is 4 ns.
    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 7;
    // The longest quiet stretch of a correct run is the long receiver hold-off,
    // plus a divider pass and a few random stalls, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    // The final wait is long enough to cover a segment close with its divider pass.
    localparam int DRAIN_CYCLES   = 64;
    // Enough strong samples to pass the maximum count of the long segment test.
    localparam int LONG_ITEMS     = 120;
    localparam int RAND_ITEMS     = 120;

    // Clock and reset.
    logic i_clk;
    logic i_rst_n = 1'b0;

    // Input item channel, driven by the sender.
    logic              in_valid = 1'b0;
    spm_pkg::t_in_item in_data  = '0;
    logic              in_stall;

    // Result channel, stalled by the receiver.
    logic               out_valid;
    logic               out_stall = 1'b0;
    spm_pkg::t_out_item out_data;

    // Configuration port.
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [spm_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [spm_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [spm_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    segmented_prediction_mse_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Our own copy of the block's state. It is advanced once per accepted input
    // transfer, so it always describes the block as seen by the next item.
    logic signed [spm_pkg::ERR_W-1:0] err_ring [NA][ND];
    int                               wr_ptr;
    logic signed [spm_pkg::SMP_W-1:0] prev_pred [NA];
    logic signed [spm_pkg::LBL_W-1:0] prev_label;
    logic [SW-1:0]                    sq_sum [NA];
    logic [spm_pkg::CNT_W-1:0]        seg_count;
    spm_pkg::t_cfg                    cfg_shadow;

    // Results still owed by the block, oldest first.
    spm_pkg::t_out_item mse_expected [$];

    int mismatch_count = 0;

    // Random idling of both sides, in percent of cycles.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    // A test asks for a long receiver hold-off by bumping this counter; the
    // receiver process notices the change and counts the hold-off on its own.
    int holdoff_reqs = 0;
    int holdoff_seen = 0;
    int holdoff_left = 0;

    int idle_cycles = 0;

    function automatic void reset_predictor();
        for (int a = 0; a < NA; a++) begin
            for (int k = 0; k < ND; k++) begin
                err_ring[a][k] = '0;
            end
            prev_pred[a] = '0;
            sq_sum[a]    = '0;
        end
        wr_ptr                 = 0;
        prev_label             = '0;
        seg_count              = '0;
        cfg_shadow.strong_low  = spm_pkg::STRONG_LOW_RST;
        cfg_shadow.strong_high = spm_pkg::STRONG_HIGH_RST;
        cfg_shadow.max_count   = spm_pkg::MAX_COUNT_RST;
        cfg_shadow.min_count   = spm_pkg::MIN_COUNT_RST;
    endfunction

    // Works out the result of one item and advances the state copy.
    function automatic spm_pkg::t_out_item predict_segment_mse(input spm_pkg::t_in_item item);
        spm_pkg::t_out_item               res;
        logic signed [spm_pkg::SMP_W-1:0] pred_v [NA];
        logic signed [spm_pkg::SMP_W-1:0] act_v [NA];
        logic signed [spm_pkg::LBL_W-1:0] lbl;
        logic [SW-1:0]                    quo;
        int                               rd_ptr;
        int                               e;
        longint unsigned                  mag;

        lbl       = item.state;
        pred_v[0] = item.predicted_x;
        pred_v[1] = item.predicted_y;
        pred_v[2] = item.predicted_z;
        act_v[0]  = item.actual_x;
        act_v[1]  = item.actual_y;
        act_v[2]  = item.actual_z;

        // The new error is the sample minus the prediction made one step earlier.
        for (int a = 0; a < NA; a++) begin
            err_ring[a][wr_ptr] = {act_v[a][spm_pkg::SMP_W-1], act_v[a]}
                                - {prev_pred[a][spm_pkg::SMP_W-1], prev_pred[a]};
            prev_pred[a] = pred_v[a];
        end
        wr_ptr = (wr_ptr + 1) % ND;
        // The squared error comes from the entry one past the advanced pointer.
        rd_ptr = (wr_ptr + 1) % ND;

        res = '0;
        if ((lbl != prev_label && seg_count != 0) || seg_count > cfg_shadow.max_count) begin
            res.segment_done    = 1'b1;
            res.segment_trusted = (seg_count >= cfg_shadow.min_count);
            for (int a = 0; a < NA; a++) begin
                quo = sq_sum[a] / {{(SW-spm_pkg::CNT_W){1'b0}}, seg_count};
                case (a)
                    0:       res.mean_sq_x = quo[MW-1:0];
                    1:       res.mean_sq_y = quo[MW-1:0];
                    default: res.mean_sq_z = quo[MW-1:0];
                endcase
                sq_sum[a] = '0;
            end
            seg_count = '0;
        end else if (lbl >= cfg_shadow.strong_low && lbl <= cfg_shadow.strong_high) begin
            // A saturated count freezes the sums as well.
            if (seg_count != spm_pkg::COUNT_LIMIT) begin
                for (int a = 0; a < NA; a++) begin
                    e         = err_ring[a][rd_ptr];
                    mag       = longint'((e < 0) ? -e : e);
                    sq_sum[a] = sq_sum[a] + SW'(mag * mag);
                end
                seg_count = seg_count + 1'b1;
            end
        end else begin
            for (int a = 0; a < NA; a++) begin
                sq_sum[a] = '0;
            end
            seg_count = '0;
        end
        prev_label = lbl;
        return res;
    endfunction

    function automatic spm_pkg::t_in_item make_item(input int lbl, input int px, input int py,
                                                    input int pz, input int ax, input int ay,
                                                    input int az);
        spm_pkg::t_in_item item;
        item.state       = lbl[spm_pkg::LBL_W-1:0];
        item.predicted_x = px[spm_pkg::SMP_W-1:0];
        item.predicted_y = py[spm_pkg::SMP_W-1:0];
        item.predicted_z = pz[spm_pkg::SMP_W-1:0];
        item.actual_x    = ax[spm_pkg::SMP_W-1:0];
        item.actual_y    = ay[spm_pkg::SMP_W-1:0];
        item.actual_z    = az[spm_pkg::SMP_W-1:0];
        return item;
    endfunction

    // Mostly uniform samples, with the corner values mixed in now and then.
    function automatic int rand_sample();
        case ($urandom_range(0, 11))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Labels come in runs so that segments build up; a run ends with a jump to
    // another strong label or, less often, to any label at all.
    function automatic int next_label(input int cur, input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return int'($urandom_range(0, 255)) - 128;
        end
        if (r < 12) begin
            return lo + int'($urandom_range(0, hi - lo));
        end
        return cur;
    endfunction

    task automatic check_field(input string name, input logic [MW-1:0] want,
                               input logic [MW-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Offers one item and returns at the edge where it is transferred. The valid
    // is left high so that a following item goes out without a bubble; anything
    // that spends time afterwards lowers it first.
    task automatic send_item(input spm_pkg::t_in_item item);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        mse_expected.push_back(predict_segment_mse(item));
    endtask

    // Stops offering items and waits until every owed result has been taken.
    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        while (mse_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
    endtask

    // One register write: a setup cycle, then an access cycle that completes on
    // pready. The select is left high so that writes can follow back to back.
    task automatic apb_write(input spm_pkg::t_reg_idx idx,
                             input logic [spm_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            spm_pkg::REG_STRONG_LOW:  cfg_shadow.strong_low  = value[spm_pkg::LBL_W-1:0];
            spm_pkg::REG_STRONG_HIGH: cfg_shadow.strong_high = value[spm_pkg::LBL_W-1:0];
            spm_pkg::REG_MAX_COUNT:   cfg_shadow.max_count   = value[spm_pkg::CNT_W-1:0];
            default:                  cfg_shadow.min_count   = value[spm_pkg::CNT_W-1:0];
        endcase
    endtask

    // Registers are only written while the block has nothing in flight.
    task automatic configure(input int lo, input int hi, input int max_c, input int min_c);
        wait_drained(SETTLE_CYCLES);
        apb_write(spm_pkg::REG_STRONG_LOW,  spm_pkg::APB_DATA_W'(lo & 'hFF));
        apb_write(spm_pkg::REG_STRONG_HIGH, spm_pkg::APB_DATA_W'(hi & 'hFF));
        apb_write(spm_pkg::REG_MAX_COUNT,   spm_pkg::APB_DATA_W'(max_c & 'h1FFF));
        apb_write(spm_pkg::REG_MIN_COUNT,   spm_pkg::APB_DATA_W'(min_c & 'h1FFF));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Field extremes and the edges of the strong range under the reset settings.
    // Segments here are short, so every close is an untrusted one.
    task automatic test_field_extremes();
        send_item(make_item(9, -32768, -32768, -32768, 32767, 32767, 32767));
        send_item(make_item(9, 32767, 32767, 32767, -32768, -32768, -32768));
        send_item(make_item(14, 0, 0, 0, 32767, -32768, 0));
        send_item(make_item(14, -1, -1, -1, -1, -1, -1));
        send_item(make_item(10, 1, 2, 3, 4, 5, 6));
        send_item(make_item(127, 32767, -32768, 32767, -32768, 32767, -32768));
        send_item(make_item(-128, -32768, 32767, -32768, 32767, -32768, 32767));
        send_item(make_item(8, 100, -100, 200, -200, 300, -300));
        send_item(make_item(15, -32768, -32768, -32768, -32768, -32768, -32768));
        send_item(make_item(12, 32767, 32767, 32767, 32767, 32767, 32767));
        send_item(make_item(12, -32768, 0, 32767, 32767, 0, -32768));
        send_item(make_item(12, 5, 5, 5, -5, -5, -5));
        send_item(make_item(-128, 0, 0, 0, 0, 0, 0));
    endtask

    // Register extremes: a zero maximum count that closes each segment after one sample,
    // an empty strong range, and a single-label range with a minimum one above the
    // maximum count.
    task automatic test_register_extremes();
        configure(-128, 127, 0, 0);
        send_item(make_item(-128, -32768, -32768, -32768, 32767, 32767, 32767));
        send_item(make_item(-128, 32767, 32767, 32767, -32768, -32768, -32768));
        send_item(make_item(127, 1, -1, 1, -1, 1, -1));
        send_item(make_item(127, 0, 0, 0, 32767, 32767, 32767));

        configure(127, -128, 8191, 8191);
        send_item(make_item(0, 32767, 32767, 32767, -32768, -32768, -32768));
        send_item(make_item(127, 0, 0, 0, 0, 0, 0));
        send_item(make_item(-128, -1, -1, -1, 1, 1, 1));

        configure(-1, -1, 1, 2);
        send_item(make_item(-1, 32767, -32768, 32767, -32768, 32767, -32768));
        send_item(make_item(-1, -32768, 32767, -32768, 32767, -32768, 32767));
        send_item(make_item(-1, 7, 7, 7, 9, 9, 9));
        send_item(make_item(-1, 0, 0, 0, 0, 0, 0));
        send_item(make_item(0, 0, 0, 0, 0, 0, 0));
    endtask

    // One long strong segment of maximal errors runs past the maximum count and
    // closes as a trusted segment with large sums; the samples after it start a
    // new segment that a label change then closes untrusted.
    task automatic test_long_segment();
        configure(-128, 127, 100, 60);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int i = 0; i < LONG_ITEMS; i++) begin
            send_item(make_item(3, -32768, -32768, -32768, 32767, 32767, 32767));
        end
        send_item(make_item(4, 0, 0, 0, 0, 0, 0));
    endtask

    // Random segments under a random setting. With pressure set, the receiver
    // holds off for a long stretch while items keep coming, and later the sender
    // pauses until every owed result has been taken.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items, input bit pressure);
        int lo;
        int hi;
        int lbl;
        lo = int'($urandom_range(0, 200)) - 128;
        hi = lo + int'($urandom_range(0, 40));
        if (hi > 127) begin
            hi = 127;
        end
        configure(lo, hi, $urandom_range(1, 60), $urandom_range(0, 24));
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        lbl = lo;
        for (int i = 0; i < n_items; i++) begin
            if (pressure && i == n_items / 3) begin
                holdoff_reqs++;
            end
            if (pressure && i == 2 * n_items / 3) begin
                wait_drained(SETTLE_CYCLES);
            end
            lbl = next_label(lbl, lo, hi);
            send_item(make_item(lbl, rand_sample(), rand_sample(), rand_sample(),
                                rand_sample(), rand_sample(), rand_sample()));
        end
    endtask

    // Receiver: checks each result transfer against the oldest expectation,
    // then decides whether to stall in the next cycle. The stall value read here
    // is the one in force at this edge, since the new one lands after it.
    always @(posedge i_clk) begin
        spm_pkg::t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (mse_expected.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, out_data);
                mismatch_count++;
            end else begin
                want = mse_expected.pop_front();
                check_field("segment_done", MW'(want.segment_done),
                            MW'(out_data.segment_done));
                check_field("segment_trusted", MW'(want.segment_trusted),
                            MW'(out_data.segment_trusted));
                check_field("mean_sq_x", want.mean_sq_x, out_data.mean_sq_x);
                check_field("mean_sq_y", want.mean_sq_y, out_data.mean_sq_y);
                check_field("mean_sq_z", want.mean_sq_z, out_data.mean_sq_z);
            end
        end
        if (holdoff_seen != holdoff_reqs) begin
            holdoff_seen = holdoff_reqs;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
        end
    end

    // Watchdog: any transfer on either channel or the configuration port counts
    // as progress. A long run of cycles without one means the block is stuck.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable && pwrite && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_register_extremes();
        test_long_segment();
        // Idling: a slow receiver first, then a slow sender, then neither side.
        test_random_traffic(23, 74, RAND_ITEMS, 1'b1);
        test_random_traffic(74, 23, RAND_ITEMS, 1'b1);
        test_random_traffic(0, 0, RAND_ITEMS, 1'b0);

        wait_drained(DRAIN_CYCLES);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
src/spm_pkg.sv
src/spm_regs.sv
src/spm_divider.sv
src/spm_datapath.sv
src/spm_ctrl.sv
src/segmented_prediction_mse_core.sv
src/spm_checker.sv
sim/segmented_prediction_mse_core_tb.sv
